>>> sv/mtgl_pkg.sv
// Shared types, codes and helpers for the markup text glyph layout block.
`default_nettype none
package mtgl_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

  localparam logic [1:0] CMD_TEXT    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_SIZE    = 3'd1;
  localparam logic [2:0] KIND_THICK   = 3'd2;
  localparam logic [2:0] KIND_COLOR   = 3'd3;
  localparam logic [2:0] KIND_RESTORE = 3'd4;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_C     = 8'h63;

  localparam logic [15:0] SCALE_ONE     = 16'd8192;
  localparam logic [15:0] THICK_DEFAULT = 16'd4096;
  localparam logic [31:0] COLOR_DEFAULT = 32'hFFFF_FFFF;
  localparam logic [15:0] LINE_FACTOR   = 16'd43647;  // 0.666 in Q0.16
  localparam logic [4:0]  TAG_CAP       = 5'd18;

  // level*51200/255 rounded: ((v*51200 + 127) * ceil(2^32/255)) >> 32
  localparam logic [47:0] LEVEL_MUL = 48'd862362112000;
  localparam logic [47:0] LEVEL_ADD = 48'd2139062270;

  localparam logic signed [26:0] SUM_MAX = 27'sd8388607;
  localparam logic signed [26:0] SUM_MIN = -27'sd8388608;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] drop_base;   // height * LINE_FACTOR
  } mtgl_metric_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] thick;
    logic [31:0] color;
  } mtgl_style_t;

  typedef struct packed {
    logic       go;
    logic [1:0] cmd;
    logic [7:0] code;
  } mtgl_step_t;

  function automatic logic [15:0] level_q13(input logic [7:0] v);
    logic [47:0] prod;
    prod = 48'(v) * LEVEL_MUL + LEVEL_ADD;
    return prod[47:32];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > SUM_MAX) r = 24'sh7FFFFF;
    else if (v < SUM_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/mtgl_metrics.sv
// Glyph metric tables with per-entry valid bits and registered read.
`default_nettype none
module mtgl_metrics
  import mtgl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic         rd_en,
  input  wire logic [7:0]   code,
  input  wire logic [15:0]  wr_width,
  input  wire logic [15:0]  wr_height,
  output mtgl_metric_t      metric
);

  logic [15:0] width_mem  [GLYPH_COUNT];
  logic [15:0] height_mem [GLYPH_COUNT];
  logic [31:0] drop_mem   [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] vld_r;

  logic                   in_range;
  logic [GLYPH_IDX_W-1:0] idx;
  logic [31:0]            drop_base;
  mtgl_metric_t           rd_r;
  logic                   rd_ok_r;

  assign in_range  = {1'b0, code} < 9'(GLYPH_COUNT);
  assign idx       = code[GLYPH_IDX_W-1:0];
  assign drop_base = wr_height * LINE_FACTOR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en && in_range) begin
      vld_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      width_mem[idx]  <= wr_width;
      height_mem[idx] <= wr_height;
      drop_mem[idx]   <= drop_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (rd_en) begin
      rd_ok_r <= in_range && vld_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.width     <= width_mem[idx];
      rd_r.height    <= height_mem[idx];
      rd_r.drop_base <= drop_mem[idx];
    end
  end

  assign metric = rd_ok_r ? rd_r : '0;

endmodule
`default_nettype wire

>>> sv/mtgl_style.sv
// Inline tag parser and current size, thickness and color state.
`default_nettype none
module mtgl_style
  import mtgl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  mtgl_step_t  step,
  output logic        emit,
  output mtgl_style_t style
);

  logic        tag_active_r, tag_active_nxt;
  logic [4:0]  tag_off_r, tag_off_nxt;
  logic [2:0]  tag_kind_r, tag_kind_nxt;
  logic [7:0]  digit_r, digit_nxt;
  logic [23:0] color_acc_r, color_acc_nxt;
  mtgl_style_t style_r, style_nxt;

  logic [4:0]  off;
  logic [4:0]  rel;
  logic [1:0]  pos;
  logic [7:0]  dig;
  logic [4:0]  close_at;

  function automatic logic [7:0] digit_step(input logic [1:0] p, input logic [7:0] acc,
                                            input logic [7:0] b);
    logic [7:0] r;
    unique case (p)
      2'd0:    r = b;
      2'd1:    r = 8'(acc * 8'd10 + b);
      default: r = 8'(acc * 8'd10 + b + 8'd48);
    endcase
    return r;
  endfunction

  assign emit  = (step.cmd == CMD_TEXT) && !tag_active_r && (step.code != CH_LT);
  assign style = style_r;

  always_comb begin
    tag_active_nxt = tag_active_r;
    tag_off_nxt    = tag_off_r;
    tag_kind_nxt   = tag_kind_r;
    digit_nxt      = digit_r;
    color_acc_nxt  = color_acc_r;
    style_nxt      = style_r;
    off            = (tag_off_r < TAG_CAP) ? tag_off_r + 5'd1 : TAG_CAP;
    rel            = off - 5'd3;
    pos            = rel[1:0];
    dig            = digit_step(pos, digit_r, step.code);
    close_at       = 5'd1;
    if (step.go) begin
      if (step.cmd == CMD_RESTART) begin
        tag_active_nxt = 1'b0;
        tag_off_nxt    = '0;
        tag_kind_nxt   = KIND_NONE;
        digit_nxt      = '0;
        color_acc_nxt  = '0;
      end else if (step.cmd == CMD_TEXT) begin
        if (tag_active_r) begin
          tag_off_nxt = off;
          if (off == 5'd1) begin
            priority if (step.code == CH_S)     tag_kind_nxt = KIND_SIZE;
            else if (step.code == CH_T)         tag_kind_nxt = KIND_THICK;
            else if (step.code == CH_C)         tag_kind_nxt = KIND_COLOR;
            else if (step.code == CH_SLASH)     tag_kind_nxt = KIND_RESTORE;
            else                                tag_kind_nxt = KIND_NONE;
          end else if (tag_kind_r == KIND_SIZE || tag_kind_r == KIND_THICK) begin
            if (off >= 5'd3 && off <= 5'd5) begin
              digit_nxt = dig;
              if (off == 5'd5) begin
                if (tag_kind_r == KIND_SIZE) style_nxt.scale = level_q13(dig);
                else style_nxt.thick = level_q13(dig);
              end
            end
          end else if (tag_kind_r == KIND_COLOR) begin
            if (off >= 5'd3 && off <= 5'd17 && pos != 2'd3) begin
              digit_nxt = dig;
              if (pos == 2'd2) begin
                if (off < 5'd17) color_acc_nxt = {color_acc_r[15:0], dig};
                else style_nxt.color = {color_acc_r, dig};
              end
            end
          end else if (tag_kind_r == KIND_RESTORE && off == 5'd2) begin
            if (step.code == CH_S) style_nxt.scale = SCALE_ONE;
            else if (step.code == CH_C) style_nxt.color = COLOR_DEFAULT;
            else if (step.code == CH_T) style_nxt.thick = THICK_DEFAULT;
          end
          unique case (tag_kind_nxt)
            KIND_SIZE, KIND_THICK: close_at = 5'd5;
            KIND_COLOR:            close_at = 5'd17;
            KIND_RESTORE:          close_at = 5'd2;
            default:               close_at = 5'd1;
          endcase
          if (step.code == CH_GT && off >= close_at) tag_active_nxt = 1'b0;
        end else if (step.code == CH_LT) begin
          tag_active_nxt = 1'b1;
          tag_off_nxt    = '0;
          tag_kind_nxt   = KIND_NONE;
          digit_nxt      = '0;
          color_acc_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_active_r <= 1'b0;
      tag_off_r    <= '0;
      tag_kind_r   <= KIND_NONE;
      digit_r      <= '0;
      color_acc_r  <= '0;
      style_r      <= '{scale: SCALE_ONE, thick: THICK_DEFAULT, color: COLOR_DEFAULT};
    end else begin
      tag_active_r <= tag_active_nxt;
      tag_off_r    <= tag_off_nxt;
      tag_kind_r   <= tag_kind_nxt;
      digit_r      <= digit_nxt;
      color_acc_r  <= color_acc_nxt;
      style_r      <= style_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/mtgl_pen.sv
// Pen position state, glyph placement and advance arithmetic.
`default_nettype none
module mtgl_pen
  import mtgl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  mtgl_step_t               step,
  input  wire logic                emit,
  input  mtgl_metric_t             metric,
  input  wire logic [15:0]         scale,
  input  wire logic signed [23:0]  start_x,
  input  wire logic signed [23:0]  start_y,
  output logic signed [23:0]       pos_x,
  output logic signed [23:0]       pos_y
);

  logic signed [23:0] pen_x_r, pen_x_nxt;
  logic signed [23:0] pen_y_r, pen_y_nxt;

  logic signed [16:0] sdiff;
  logic signed [33:0] yprod;
  logic signed [24:0] yofs;
  logic signed [26:0] ysum;
  logic [31:0]        wprod;
  logic [23:0]        adv;
  logic signed [26:0] xsum;
  logic [47:0]        lprod;
  logic [23:0]        drop;
  logic signed [26:0] ynl;

  assign sdiff = $signed({1'b0, scale}) - $signed({1'b0, SCALE_ONE});
  assign yprod = sdiff * $signed({1'b0, metric.height});
  assign yofs  = 25'((yprod + 34'sd256) >>> 9);
  assign ysum  = 27'(pen_y_r) + 27'(yofs);

  assign wprod = metric.width * scale;
  assign adv   = 24'((33'(wprod) + 33'd256) >> 9);
  assign xsum  = 27'(pen_x_r) + $signed({3'b000, adv});

  assign lprod = metric.drop_base * scale;
  assign drop  = 24'((49'(lprod) + 49'h100_0000) >> 25);
  assign ynl   = 27'(pen_y_r) - $signed({3'b000, drop});

  assign pos_x = pen_x_r;
  assign pos_y = sat24(ysum);

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (step.go) begin
      if (step.cmd == CMD_RESTART) begin
        pen_x_nxt = start_x;
        pen_y_nxt = start_y;
      end else if (emit) begin
        if (step.code == CH_NL) begin
          pen_x_nxt = start_x;
          pen_y_nxt = sat24(ynl);
        end else begin
          pen_x_nxt = sat24(xsum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/markup_text_glyph_layout.sv
// Markup text glyph layout top level: handshakes, item stage, result register, APB.
// A text transaction is registered in the item stage at accept, then in the result register.
// Throughput: one transaction per cycle while the output is not stalled; the metric table read
// is registered at accept, the pen and tag state update when the item stage advances.
// Reset (rst_n low at a clock edge): pen at 0, scale 1.0, thickness 0.5, color all ones,
// no open tag, start registers 0, every table entry reads zero until loaded.
`default_nettype none
module markup_text_glyph_layout
  import mtgl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [15:0]        in_glyph_width,
  input  wire logic [15:0]        in_glyph_height,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_glyph_code,
  output logic signed [23:0]      out_pos_x,
  output logic signed [23:0]      out_pos_y,
  output logic [15:0]             out_glyph_scale,
  output logic [15:0]             out_stroke_thickness,
  output logic [7:0]              out_color_red,
  output logic [7:0]              out_color_green,
  output logic [7:0]              out_color_blue,
  output logic [7:0]              out_color_alpha,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic               in_acc;
  logic               s1_v_r;
  logic [1:0]         s1_cmd_r;
  logic [7:0]         s1_code_r;
  logic               emit;
  logic               s1_emit;
  logic               out_free;
  logic               s1_go;
  mtgl_step_t         step;
  mtgl_metric_t       metric;
  mtgl_style_t        style;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] start_x_r;
  logic signed [23:0] start_y_r;
  logic               cfg_wr;

  logic               out_valid_r;
  logic [7:0]         out_code_r;
  logic signed [23:0] out_x_r;
  logic signed [23:0] out_y_r;
  mtgl_style_t        out_style_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_emit  = s1_v_r && emit;
  assign s1_go    = s1_v_r && (!emit || out_free);
  assign in_stall = s1_v_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  assign step = '{go: s1_go, cmd: s1_cmd_r, code: s1_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_cmd;
      s1_code_r <= in_char_code;
    end
  end

  mtgl_metrics u_metrics (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc && in_cmd == CMD_LOAD),
    .rd_en     (in_acc),
    .code      (in_char_code),
    .wr_width  (in_glyph_width),
    .wr_height (in_glyph_height),
    .metric    (metric)
  );

  mtgl_style u_style (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .emit  (emit),
    .style (style)
  );

  mtgl_pen u_pen (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .emit    (emit),
    .metric  (metric),
    .scale   (style.scale),
    .start_x (start_x_r),
    .start_y (start_y_r),
    .pos_x   (pos_x),
    .pos_y   (pos_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_emit) begin
      out_code_r  <= s1_code_r;
      out_x_r     <= pos_x;
      out_y_r     <= pos_y;
      out_style_r <= style;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_glyph_code       = out_code_r;
  assign out_pos_x            = out_x_r;
  assign out_pos_y            = out_y_r;
  assign out_glyph_scale      = out_style_r.scale;
  assign out_stroke_thickness = out_style_r.thick;
  assign out_color_red        = out_style_r.color[31:24];
  assign out_color_green      = out_style_r.color[23:16];
  assign out_color_blue       = out_style_r.color[15:8];
  assign out_color_alpha      = out_style_r.color[7:0];

  // word decode on paddr[2]; byte offset bits ignored
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) start_y_r <= pwdata[23:0];
      else start_x_r <= pwdata[23:0];
    end
  end

  assign prdata = paddr[2] ? 32'(start_y_r) : 32'(start_x_r);

  logic unused_paddr;
  assign unused_paddr = ^paddr[1:0];

endmodule
`default_nettype wire

>>> bench/glyph_layout_checker.sv
// Glyph layout checker: watches both channels and the APB port, predicts glyph transactions.
module glyph_layout_checker
  import mtgl_pkg::*;
#(
  parameter logic [2:0] ADDR_START_X = 3'd0,
  parameter logic [2:0] ADDR_START_Y = 3'd4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_glyph_width,
  input  logic [15:0] in_glyph_height,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_glyph_code,
  input  logic [23:0] out_pos_x,
  input  logic [23:0] out_pos_y,
  input  logic [15:0] out_glyph_scale,
  input  logic [15:0] out_stroke_thickness,
  input  logic [7:0]  out_color_red,
  input  logic [7:0]  out_color_green,
  input  logic [7:0]  out_color_blue,
  input  logic [7:0]  out_color_alpha,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          fail_count
);

  typedef struct {
    logic [7:0]  code;
    logic [23:0] x;
    logic [23:0] y;
    logic [15:0] scale;
    logic [15:0] thick;
    logic [31:0] color;
  } glyph_rec_t;

  glyph_rec_t placed_q[$];

  logic [15:0]        width_mem [GLYPH_COUNT];
  logic [15:0]        height_mem[GLYPH_COUNT];
  logic signed [23:0] org_x, org_y, pen_x, pen_y;
  logic [15:0]        scale, thick;
  logic [31:0]        color;
  logic               tag_open;
  logic [4:0]         tag_pos;
  logic [2:0]         tag_kind;
  logic [7:0]         digits;
  logic [23:0]        color_acc;

  initial begin
    pending = 0;
    fail_count = 0;
  end

  function automatic logic signed [23:0] clamp_pen(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  function automatic logic [15:0] level_to_style(input logic [7:0] v);
    return 16'((int'(v) * 51200 + 127) / 255);
  endfunction

  task automatic reset_tag();
    tag_open = 1'b0;
    tag_pos = '0;
    tag_kind = KIND_NONE;
    digits = '0;
    color_acc = '0;
  endtask

  // three raw bytes a,b,c give (100a + 10b + c - 208) mod 256
  task automatic push_digit(input int pos, input logic [7:0] b);
    if (pos == 0) digits = b;
    else if (pos == 1) digits = 8'(int'(digits) * 10 + int'(b));
    else digits = 8'(int'(digits) * 10 + int'(b) + 256 - 208);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : track
    logic [7:0]  b;
    logic [15:0] w, h;
    int          off, pos, close_at;
    longint      rise, drop, adv;
    glyph_rec_t  rec;

    if (!rst_n) begin
      for (int i = 0; i < GLYPH_COUNT; i++) begin
        width_mem[i] = '0;
        height_mem[i] = '0;
      end
      org_x = '0;
      org_y = '0;
      pen_x = '0;
      pen_y = '0;
      scale = SCALE_ONE;
      thick = THICK_DEFAULT;
      color = COLOR_DEFAULT;
      reset_tag();
      placed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (placed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: glyph transaction with none predicted, code %h",
                     $time, out_glyph_code);
        end else begin
          rec = placed_q.pop_front();
          if (out_glyph_code !== rec.code)
            note_mismatch("glyph_code", 32'(rec.code), 32'(out_glyph_code));
          if (out_pos_x !== rec.x) note_mismatch("pos_x", 32'(rec.x), 32'(out_pos_x));
          if (out_pos_y !== rec.y) note_mismatch("pos_y", 32'(rec.y), 32'(out_pos_y));
          if (out_glyph_scale !== rec.scale)
            note_mismatch("glyph_scale", 32'(rec.scale), 32'(out_glyph_scale));
          if (out_stroke_thickness !== rec.thick)
            note_mismatch("stroke_thickness", 32'(rec.thick), 32'(out_stroke_thickness));
          if (out_color_red !== rec.color[31:24])
            note_mismatch("color_red", 32'(rec.color[31:24]), 32'(out_color_red));
          if (out_color_green !== rec.color[23:16])
            note_mismatch("color_green", 32'(rec.color[23:16]), 32'(out_color_green));
          if (out_color_blue !== rec.color[15:8])
            note_mismatch("color_blue", 32'(rec.color[15:8]), 32'(out_color_blue));
          if (out_color_alpha !== rec.color[7:0])
            note_mismatch("color_alpha", 32'(rec.color[7:0]), 32'(out_color_alpha));
        end
      end

      if (in_valid && !in_stall) begin
        b = in_char_code;
        if (in_cmd == CMD_LOAD) begin
          if (int'(b) < GLYPH_COUNT) begin
            width_mem[b] = in_glyph_width;
            height_mem[b] = in_glyph_height;
          end
        end else if (in_cmd == CMD_RESTART) begin
          pen_x = org_x;
          pen_y = org_y;
          reset_tag();
        end else if (in_cmd == CMD_TEXT) begin
          if (tag_open) begin
            off = (tag_pos < TAG_CAP) ? int'(tag_pos) + 1 : int'(TAG_CAP);
            tag_pos = 5'(off);
            if (off == 1) begin
              case (b)
                CH_S:     tag_kind = KIND_SIZE;
                CH_T:     tag_kind = KIND_THICK;
                CH_C:     tag_kind = KIND_COLOR;
                CH_SLASH: tag_kind = KIND_RESTORE;
                default:  tag_kind = KIND_NONE;
              endcase
            end else if (tag_kind == KIND_SIZE || tag_kind == KIND_THICK) begin
              if (off >= 3 && off <= 5) begin
                push_digit(off - 3, b);
                if (off == 5) begin
                  if (tag_kind == KIND_SIZE) scale = level_to_style(digits);
                  else thick = level_to_style(digits);
                end
              end
            end else if (tag_kind == KIND_COLOR) begin
              if (off >= 3 && off <= 17 && ((off - 3) & 3) != 3) begin
                pos = (off - 3) & 3;
                push_digit(pos, b);
                if (pos == 2) begin
                  if (off < 17) color_acc = {color_acc[15:0], digits};
                  else color = {color_acc, digits};
                end
              end
            end else if (tag_kind == KIND_RESTORE && off == 2) begin
              case (b)
                CH_S:    scale = SCALE_ONE;
                CH_C:    color = COLOR_DEFAULT;
                CH_T:    thick = THICK_DEFAULT;
                default: ;
              endcase
            end
            if (tag_kind == KIND_SIZE || tag_kind == KIND_THICK) close_at = 5;
            else if (tag_kind == KIND_COLOR) close_at = 17;
            else if (tag_kind == KIND_RESTORE) close_at = 2;
            else close_at = 1;
            if (b == CH_GT && off >= close_at) tag_open = 1'b0;
          end else if (b == CH_LT) begin
            reset_tag();
            tag_open = 1'b1;
          end else begin
            w = (int'(b) < GLYPH_COUNT) ? width_mem[b] : 16'd0;
            h = (int'(b) < GLYPH_COUNT) ? height_mem[b] : 16'd0;
            rise = ((longint'(scale) - longint'(SCALE_ONE)) * longint'(h) + 64'sd256) >>> 9;
            rec.code = b;
            rec.x = pen_x;
            rec.y = clamp_pen(longint'(pen_y) + rise);
            rec.scale = scale;
            rec.thick = thick;
            rec.color = color;
            placed_q.push_back(rec);
            if (b == CH_NL) begin
              drop = (longint'(h) * longint'(scale) * longint'(LINE_FACTOR)
                      + 64'sd16777216) >>> 25;
              pen_x = org_x;
              pen_y = clamp_pen(longint'(pen_y) - drop);
            end else begin
              adv = (longint'(w) * longint'(scale) + 64'sd256) >>> 9;
              pen_x = clamp_pen(longint'(pen_x) + adv);
            end
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_START_X) org_x = pwdata[23:0];
        else if (paddr == ADDR_START_Y) org_y = pwdata[23:0];
      end
    end
    pending = placed_q.size();
  end

endmodule

>>> bench/tb_top.sv
// Glyph layout testbench top: clock, reset, text and tag stimulus, origin setup, verdict.
module tb_top;
  import mtgl_pkg::*;

  localparam logic [2:0] ADDR_START_X = 3'd0;
  localparam logic [2:0] ADDR_START_Y = 3'd4;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET  = 1550;
  localparam int         PHASES       = 6;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_char_code;
  logic [15:0] in_glyph_width;
  logic [15:0] in_glyph_height;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_glyph_code;
  logic [23:0] out_pos_x;
  logic [23:0] out_pos_y;
  logic [15:0] out_glyph_scale;
  logic [15:0] out_stroke_thickness;
  logic [7:0]  out_color_red;
  logic [7:0]  out_color_green;
  logic [7:0]  out_color_blue;
  logic [7:0]  out_color_alpha;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int fail_count;
  int sent;
  bit quiet;

  logic [7:0] glyph_set[8] = '{CH_NL, 8'h41, 8'h61, 8'h30, 8'h20, 8'h2E, 8'h57, 8'h69};

  markup_text_glyph_layout u_top (.*);

  glyph_layout_checker #(
    .ADDR_START_X(ADDR_START_X),
    .ADDR_START_Y(ADDR_START_Y)
  ) u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [7:0] code,
                      input logic [15:0] w, input logic [15:0] h);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_char_code <= code;
    in_glyph_width <= w;
    in_glyph_height <= h;
    do @(posedge clk); while (in_stall);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send(CMD_TEXT, b, 16'($urandom), 16'($urandom));
  endtask

  task automatic restart();
    send(CMD_RESTART, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_origin(input logic [31:0] x, input logic [31:0] y);
    @(negedge clk) in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    apb_write(ADDR_START_X, x);
    apb_write(ADDR_START_Y, y);
    restart();
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) < 7) return glyph_set[$urandom_range(0, 7)];
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [15:0] pick_metric();
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 12287));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] digit_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(48, 57));
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 4))
      0:       return CH_S;
      1:       return CH_T;
      2:       return CH_C;
      3:       return CH_SLASH;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_level_tag(input logic [7:0] kind);
    send_text(CH_LT);
    send_text(kind);
    send_text(8'h3D);
    repeat (3) send_text(digit_byte());
    send_text(CH_GT);
  endtask

  task automatic send_color_tag();
    send_text(CH_LT);
    send_text(CH_C);
    send_text(8'h3D);
    for (int g = 0; g < 4; g++) begin
      repeat (3) send_text(digit_byte());
      send_text(g == 3 ? CH_GT : 8'h2C);
    end
  endtask

  task automatic send_broken_tag();
    int n;
    n = $urandom_range(0, 22);
    send_text(CH_LT);
    send_text(pick_kind());
    repeat (n) send_text($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(32, 126)));
    case ($urandom_range(0, 3))
      0, 1:    send_text(CH_GT);
      2:       restart();
      default: ;
    endcase
  endtask

  initial begin
    in_valid = 1'b0;
    in_cmd = CMD_TEXT;
    in_char_code = '0;
    in_glyph_width = '0;
    in_glyph_height = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send(CMD_LOAD, 8'h41, 16'hFFFF, 16'hFFFF);
    send(CMD_LOAD, 8'hFF, 16'h0000, 16'h0000);
    send(CMD_LOAD, CH_NL, 16'h0800, 16'hFFFF);
    send_text(8'hFF);
    // size to the maximum level, then two wide glyphs push the pen into saturation
    send_text(CH_LT);
    send_text(CH_S);
    send_text(8'h3D);
    send_text(8'h32);
    send_text(8'h35);
    send_text(8'h35);
    send_text(CH_GT);
    send_text(8'h41);
    send_text(8'h41);
    send_text(CH_NL);
    send_text(CH_LT);
    send_text(CH_SLASH);
    send_text(CH_S);
    send_text(CH_GT);
    // open tag dropped by restart
    send_text(CH_LT);
    send_text(CH_C);
    send(CMD_RESTART, 8'h00, 16'h0000, 16'h0000);
    send_text(8'h00);
    send(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_origin(32'h007F_FFFF, 32'hFF80_0000);
        1:       set_origin(32'h0080_0000, 32'h7F7F_FFFF);
        2:       set_origin(32'h0000_0000, 32'h0000_0000);
        default: set_origin($urandom, $urandom);
      endcase
      while (sent < 25 + ITEM_TARGET * (p + 1) / PHASES) begin
        if ($urandom_range(0, quiet ? 15 : 63) == 0) quiet = !quiet;
        case ($urandom_range(0, 15))
          0, 1:          send(CMD_LOAD, pick_code(), pick_metric(), pick_metric());
          2, 3, 4, 5, 6: send_text(pick_code());
          7:             send_text(CH_NL);
          8:             send_level_tag(CH_S);
          9:             send_level_tag(CH_T);
          10:            send_color_tag();
          11: begin
            send_text(CH_LT);
            send_text(CH_SLASH);
            case ($urandom_range(0, 3))
              0:       send_text(CH_S);
              1:       send_text(CH_C);
              2:       send_text(CH_T);
              default: send_text(8'h78);
            endcase
            send_text(CH_GT);
          end
          12:            send_broken_tag();
          13:            restart();
          14:            send_text(8'($urandom));
          default:       send(CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
